[sv/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared constants, register codes and rounding and saturation helpers of the UV sphere
// vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int CNT_W     = 9;   // counts and grid indexes
  localparam int DVD_W     = 28;  // index followed by 19 fraction bits
  localparam int DIV_STEPS = DVD_W;
  localparam int ANG_W     = 18;  // angle in 1/2^18 turn
  localparam int SIN_LAT   = 8;
  localparam int DEF_MAX_SEGMENTS = 256;
  localparam int DEF_MAX_RINGS    = 256;

  // taylor coefficients of sin(x*pi/2), Q1.30
  localparam logic [30:0] K1 = 31'd1686629713;
  localparam logic [30:0] K3 = 31'd693598668;
  localparam logic [30:0] K5 = 31'd85569306;
  localparam logic [30:0] K7 = 31'd5026995;
  localparam logic [30:0] K9 = 31'd172272;
  localparam logic [31:0] ONE_Q30 = 32'd1073741824;

  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_SEGMENTS = 2'd1,
    REG_RINGS    = 2'd2
  } cfg_reg_t;

  // shift right, rounding half away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m = neg ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [15:0] sat16(input logic signed [63:0] v,
                                        input logic signed [63:0] lo,
                                        input logic signed [63:0] hi);
    logic signed [63:0] c;
    c = v;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return c[15:0];
  endfunction

endpackage

[sv/uvs_div.sv]
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider: floor(numer * 2^19 / denom), one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; (
  input  logic             clk,
  input  logic [CNT_W-1:0] numer,
  input  logic [CNT_W-1:0] denom,
  output logic [DVD_W-1:0] quot
);

  logic [CNT_W-1:0] rem [DIV_STEPS];
  logic [DVD_W-1:0] dvd [DIV_STEPS];
  logic [DVD_W-1:0] quo [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [CNT_W-1:0] rem_in;
    logic [DVD_W-1:0] dvd_in;
    logic [DVD_W-1:0] quo_in;
    logic [CNT_W:0]   trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = {numer, (DVD_W - CNT_W)'(0)};
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign dvd_in = dvd[k-1];
      assign quo_in = quo[k-1];
    end

    assign trial = {rem_in, dvd_in[DVD_W-1]};
    assign fit   = trial >= {1'b0, denom};

    always_ff @(posedge clk) begin
      rem[k] <= fit ? CNT_W'(trial - {1'b0, denom}) : trial[CNT_W-1:0];
      dvd[k] <= dvd_in << 1;
      quo[k] <= {quo_in[DVD_W-2:0], fit};
    end
  end

  assign quot = quo[DIV_STEPS-1];

endmodule

[sv/uvs_sin.sv]
// ----------------------------------------------------------------------------
// uvs_sin
// Pipelined sine of an angle in 1/2^18 turn, Q2.30 signed result, from a
// ninth-order quarter-wave polynomial by Horner's rule.
// ----------------------------------------------------------------------------
module uvs_sin import uvs_pkg::*; (
  input  logic              clk,
  input  logic [ANG_W-1:0]  angle,
  output logic signed [31:0] sin_q30
);

  logic [16:0] f_in;
  logic [16:0] f1;
  logic        neg [7];
  logic [30:0] x    [2:6];
  logic [30:0] x2   [2:5];
  logic [61:0] p3, p4, p5, p6, p7;
  logic [61:0] xx;
  logic [31:0] mag;

  // mirror the odd quadrants
  assign f_in = angle[16] ? 17'(17'd65536 - {1'b0, angle[15:0]}) : {1'b0, angle[15:0]};
  assign xx   = {f1, 14'b0} * {f1, 14'b0};

  always_ff @(posedge clk) begin
    f1     <= f_in;
    neg[0] <= angle[17];
    x[2]   <= {f1, 14'b0};
    x2[2]  <= xx[60:30];
    neg[1] <= neg[0];
    p3     <= K9 * x2[2];
    x[3]   <= x[2];
    x2[3]  <= x2[2];
    neg[2] <= neg[1];
    p4     <= 31'(K7 - p3[61:30]) * x2[3];
    x[4]   <= x[3];
    x2[4]  <= x2[3];
    neg[3] <= neg[2];
    p5     <= 31'(K5 - p4[61:30]) * x2[4];
    x[5]   <= x[4];
    x2[5]  <= x2[4];
    neg[4] <= neg[3];
    p6     <= 31'(K3 - p5[61:30]) * x2[5];
    x[6]   <= x[5];
    neg[5] <= neg[4];
    p7     <= 31'(K1 - p6[61:30]) * x[6];
    neg[6] <= neg[5];
    sin_q30 <= neg[6] ? -$signed(mag) : $signed(mag);
  end

  assign mag = (p7[61:30] > ONE_Q30) ? ONE_Q30 : p7[61:30];

endmodule

[sv/uv_sphere_vertex_generator_unit.sv]
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator_unit
// throughput: one grid point per cycle, busy is never raised
// the depth is set by the 28-step divider and the 8-stage sine units
// rst clears the valid line and loads the register reset values
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_unit import uvs_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int MAX_RINGS    = DEF_MAX_RINGS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              start,
  output logic              busy,
  input  logic [8:0]        ring_index,
  input  logic [8:0]        segment_index,
  output logic              done,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [15:0]       tex_u,
  output logic [15:0]       tex_v,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic [16:0]       vertex_number
);

  localparam int SIDE_LAT = SIN_LAT + 3;

  logic [15:0]      sphere_radius;
  logic [CNT_W-1:0] segment_count;
  logic [CNT_W-1:0] ring_count;
  logic [CNT_W-1:0] segs, rings;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 16'd256;
      segment_count <= 9'd16;
      ring_count    <= 9'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RADIUS:   sphere_radius <= cfg_data;
        REG_SEGMENTS: segment_count <= cfg_data[CNT_W-1:0];
        REG_RINGS:    ring_count    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (segment_count == '0) segs = CNT_W'(1);
    else if (32'(segment_count) > MAX_SEGMENTS) segs = CNT_W'(MAX_SEGMENTS);
    else segs = segment_count;
    if (ring_count == '0) rings = CNT_W'(1);
    else if (32'(ring_count) > MAX_RINGS) rings = CNT_W'(MAX_RINGS);
    else rings = ring_count;
  end

  assign busy = 1'b0;

  // entry stage
  logic             s0_vld;
  logic [CNT_W-1:0] s0_r, s0_s;
  logic [16:0]      s0_vnum;

  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else     s0_vld <= start && !busy;
    s0_r    <= ring_index;
    s0_s    <= segment_index;
    s0_vnum <= 17'(ring_index * (10'(segs) + 10'd1) + 19'(segment_index));
  end

  // divider stages
  logic [DVD_W-1:0] quot_s, quot_r;
  logic             dv_vld  [DIV_STEPS];
  logic [16:0]      dv_vnum [DIV_STEPS];

  uvs_div u_div_seg (.clk(clk), .numer(s0_s), .denom(segs),  .quot(quot_s));
  uvs_div u_div_ring(.clk(clk), .numer(s0_r), .denom(rings), .quot(quot_r));

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      if (rst) dv_vld[k] <= 1'b0;
      else     dv_vld[k] <= (k == 0) ? s0_vld : dv_vld[(k == 0) ? 0 : k-1];
      dv_vnum[k] <= (k == 0) ? s0_vnum : dv_vnum[(k == 0) ? 0 : k-1];
    end
  end

  // angle and texture stage
  logic [28:0]      th_w, ph_w;
  logic [25:0]      tu_w, tv_w;
  logic             a_vld;
  logic [ANG_W-1:0] a_theta, a_phi;
  logic [15:0]      a_tu, a_tv;
  logic [16:0]      a_vnum;

  assign th_w = (29'(quot_s) + 29'd1) >> 1;
  assign ph_w = (29'(quot_r >> 1) + 29'd1) >> 1;
  assign tu_w = (26'(quot_s >> 3) + 26'd1) >> 1;
  assign tv_w = (26'(quot_r >> 3) + 26'd1) >> 1;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else     a_vld <= dv_vld[DIV_STEPS-1];
    a_theta <= th_w[ANG_W-1:0];
    a_phi   <= ph_w[ANG_W-1:0];
    a_tu    <= (tu_w > 26'hFFFF) ? 16'hFFFF : tu_w[15:0];
    a_tv    <= (tv_w > 26'hFFFF) ? 16'hFFFF : tv_w[15:0];
    a_vnum  <= dv_vnum[DIV_STEPS-1];
  end

  // trig
  logic signed [31:0] sp, cp, st, ct;
  logic [ANG_W-1:0]   qturn;

  assign qturn = ANG_W'(1) << (ANG_W - 2);

  uvs_sin u_sin_phi  (.clk(clk), .angle(a_phi),                      .sin_q30(sp));
  uvs_sin u_cos_phi  (.clk(clk), .angle(ANG_W'(a_phi + qturn)),      .sin_q30(cp));
  uvs_sin u_sin_theta(.clk(clk), .angle(a_theta),                    .sin_q30(st));
  uvs_sin u_cos_theta(.clk(clk), .angle(ANG_W'(a_theta + qturn)),    .sin_q30(ct));

  // side data follows the trig and product stages
  logic        sd_vld  [SIDE_LAT];
  logic [15:0] sd_tu   [SIDE_LAT];
  logic [15:0] sd_tv   [SIDE_LAT];
  logic [16:0] sd_vnum [SIDE_LAT];

  always_ff @(posedge clk) begin
    for (int k = 0; k < SIDE_LAT; k++) begin
      if (rst) sd_vld[k] <= 1'b0;
      else     sd_vld[k] <= (k == 0) ? a_vld : sd_vld[(k == 0) ? 0 : k-1];
      sd_tu[k]   <= (k == 0) ? a_tu   : sd_tu[(k == 0) ? 0 : k-1];
      sd_tv[k]   <= (k == 0) ? a_tv   : sd_tv[(k == 0) ? 0 : k-1];
      sd_vnum[k] <= (k == 0) ? a_vnum : sd_vnum[(k == 0) ? 0 : k-1];
    end
  end

  // product stages
  logic signed [16:0] rad_s;
  logic signed [48:0] m_ring, m_py;
  logic signed [63:0] m_nx, m_nz;
  logic signed [31:0] cp1, st1, ct1, st2, ct2;
  logic signed [34:0] ring24;
  logic [15:0]        py2, nx2, ny2, nz2, py3, nx3, ny3, nz3;
  logic signed [63:0] m_px, m_pz;

  assign rad_s = $signed({1'b0, sphere_radius});

  always_ff @(posedge clk) begin
    m_ring <= sp * rad_s;
    m_py   <= cp * rad_s;
    m_nx   <= sp * st;
    m_nz   <= sp * ct;
    cp1    <= cp;
    st1    <= st;
    ct1    <= ct;

    ring24 <= 35'(shr_round(64'(m_ring), 14));
    py2    <= sat16(shr_round(64'(m_py), 30), -64'sd32768, 64'sd32767);
    if (sphere_radius == '0) begin
      nx2 <= '0;
      ny2 <= '0;
      nz2 <= '0;
    end else begin
      nx2 <= sat16(shr_round(m_nx, 46), -64'sd16384, 64'sd16384);
      ny2 <= sat16(shr_round(64'(cp1), 16), -64'sd16384, 64'sd16384);
      nz2 <= sat16(shr_round(m_nz, 46), -64'sd16384, 64'sd16384);
    end
    st2 <= st1;
    ct2 <= ct1;

    m_px <= st2 * ring24;
    m_pz <= ct2 * ring24;
    py3  <= py2;
    nx3  <= nx2;
    ny3  <= ny2;
    nz3  <= nz2;

    pos_x         <= sat16(shr_round(m_px, 46), -64'sd32768, 64'sd32767);
    pos_y         <= py3;
    pos_z         <= sat16(shr_round(m_pz, 46), -64'sd32768, 64'sd32767);
    normal_x      <= nx3;
    normal_y      <= ny3;
    normal_z      <= nz3;
    tex_u         <= sd_tu[SIDE_LAT-1];
    tex_v         <= sd_tv[SIDE_LAT-1];
    vertex_number <= sd_vnum[SIDE_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= sd_vld[SIDE_LAT-1];
  end

`ifndef SYNTHESIS
  // every result traces back to a start transfer at the fixed latency
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, 42))
    else $error("result without matching start transfer");

  assert property (@(posedge clk) disable iff (rst)
    done && sphere_radius == '0 |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("normal not zero for zero radius");

  assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
              normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
    else $error("normal out of range");
`endif

endmodule
